// ===== rtl/ple_pkg.sv =====
// Shared constants, codes and types for the positional list engine.
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 5;
   localparam int VAL_W    = 32;

   localparam logic [2:0] FN_INS_FRONT = 3'd0;
   localparam logic [2:0] FN_INS_BACK  = 3'd1;
   localparam logic [2:0] FN_INS_AT    = 3'd2;
   localparam logic [2:0] FN_DEL_FRONT = 3'd3;
   localparam logic [2:0] FN_DEL_BACK  = 3'd4;
   localparam logic [2:0] FN_DEL_AT    = 3'd5;
   localparam logic [2:0] FN_READ      = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   // shift command broadcast to every cell
   typedef struct packed {
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] value;
   } cell_cmd_type;

   // per-request result from the controller
   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
      logic             rd;
      logic [IDX_W-1:0] rd_idx;
   } ctrl_rsp_type;

endpackage

// ===== rtl/ple_cell.sv =====
// One list cell: holds a single entry and shifts with its neighbors.
module ple_cell (
   input  logic                             clock,
   input  logic [ple_pkg::IDX_W-1:0]        cell_idx,
   input  ple_pkg::cell_cmd_type            cmd,
   input  logic [ple_pkg::VAL_W-1:0]        left_value,
   input  logic [ple_pkg::VAL_W-1:0]        right_value,
   output logic [ple_pkg::VAL_W-1:0]        value
);

   logic [ple_pkg::VAL_W-1:0] value_ff;
   logic [ple_pkg::VAL_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (cell_idx == cmd.idx) begin
            value_in = cmd.value;
         end else if (cell_idx > cmd.idx) begin
            value_in = left_value;
         end
      end else if (cmd.del) begin
         if (cell_idx >= cmd.idx) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== rtl/ple_ctrl.sv =====
// Request decoder and entry count: checks each request and drives the cell shift command.
module ple_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [2:0]                       func,
   input  logic [ple_pkg::VAL_W-1:0]        item_value,
   input  logic [ple_pkg::CNT_W-1:0]        position,
   output ple_pkg::cell_cmd_type            cmd,
   output ple_pkg::ctrl_rsp_type            rsp
);

   localparam logic [ple_pkg::CNT_W-1:0] CAP_CNT = ple_pkg::CNT_W'(ple_pkg::CAPACITY);

   logic [ple_pkg::CNT_W-1:0] fill_ff;
   logic [ple_pkg::CNT_W-1:0] fill_in;
   logic [ple_pkg::CNT_W:0]   fill_plus;
   logic [ple_pkg::CNT_W-1:0] pos_m1;
   logic [ple_pkg::CNT_W-1:0] fill_m1;
   logic                      full;
   logic                      empty;
   logic                      ins;
   logic                      del;
   logic [ple_pkg::IDX_W-1:0] idx;
   logic [1:0]                status;
   logic                      rd;

   assign full      = (fill_ff >= CAP_CNT);
   assign empty     = (fill_ff == '0);
   assign fill_plus = {1'b0, fill_ff} + 1'b1;
   assign pos_m1    = position - 1'b1;
   assign fill_m1   = fill_ff - 1'b1;

   always_comb begin
      status = ple_pkg::ST_OK;
      ins    = 1'b0;
      del    = 1'b0;
      rd     = 1'b0;
      idx    = '0;
      unique case (func) inside
         ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK, ple_pkg::FN_INS_AT: begin
            if (full) begin
               status = ple_pkg::ST_FULL;
            end else if (func == ple_pkg::FN_INS_FRONT) begin
               ins = 1'b1;
            end else if (func == ple_pkg::FN_INS_BACK) begin
               ins = 1'b1;
               idx = fill_ff[ple_pkg::IDX_W-1:0];
            end else if (position == '0 || {1'b0, position} > fill_plus) begin
               status = ple_pkg::ST_BADPOS;
            end else begin
               ins = 1'b1;
               idx = pos_m1[ple_pkg::IDX_W-1:0];
            end
         end
         ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_BACK, ple_pkg::FN_DEL_AT,
         ple_pkg::FN_READ: begin
            if (empty) begin
               status = ple_pkg::ST_EMPTY;
            end else if (func == ple_pkg::FN_DEL_FRONT) begin
               del = 1'b1;
            end else if (func == ple_pkg::FN_DEL_BACK) begin
               del = 1'b1;
               idx = fill_m1[ple_pkg::IDX_W-1:0];
            end else if (position == '0 || position > fill_ff) begin
               status = ple_pkg::ST_BADPOS;
            end else if (func == ple_pkg::FN_DEL_AT) begin
               del = 1'b1;
               idx = pos_m1[ple_pkg::IDX_W-1:0];
            end else begin
               rd  = 1'b1;
               idx = pos_m1[ple_pkg::IDX_W-1:0];
            end
         end
         default: begin
            status = ple_pkg::ST_BADPOS;
         end
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept && ins) begin
         fill_in = fill_plus[ple_pkg::CNT_W-1:0];
      end else if (accept && del) begin
         fill_in = fill_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign cmd.ins    = accept & ins;
   assign cmd.del    = accept & del;
   assign cmd.idx    = idx;
   assign cmd.value  = item_value;

   assign rsp.status = status;
   assign rsp.count  = fill_in;
   assign rsp.rd     = rd;
   assign rsp.rd_idx = idx;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (accept && ins) |=> (fill_ff == $past(fill_plus[ple_pkg::CNT_W-1:0])))
      else $error("insert did not add one entry");

   a_del_count: assert property (@(posedge clock) disable iff (reset)
      (accept && del) |=> (fill_ff == $past(fill_m1)))
      else $error("delete did not remove one entry");

   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (!accept || status != ple_pkg::ST_OK || rd) |=> $stable(fill_ff))
      else $error("count changed without a successful insert or delete");

endmodule

// ===== rtl/positional_list_engine_top.sv =====
// Top level of the positional list engine: stream ports, cell chain and result register.
//
// Usage:
//   req_* carries one request per accepted beat: a function code (insert front, insert
//   back, insert before a position, delete front, delete back, delete at a position,
//   read a position), a value to insert and a one-based position.
//   rsp_* returns exactly one response per request, in order: status, entry count after
//   the operation and the value read (zero unless a read succeeds).
// Timing:
//   The response is registered and valid in the cycle after acceptance. Throughput is one
//   request per cycle while no response is held; every cell compares its own index
//   with the request's target index and shifts in the same cycle, so the cell row updates
//   at most once per request.
// Reset: the entry count clears to zero; entry contents are left as they are and are
//   never returned until written. No response is pending after reset.
// Stall: while rsp_tready is low a held response keeps req_tready low; a new request is
//   taken in the same cycle that the held response is taken.
module positional_list_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // func[2:0], item_value[34:3], position[39:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], entry_count[6:2], read_value[38:7], 0
);

   logic                          accept;
   ple_pkg::cell_cmd_type         cmd;
   ple_pkg::ctrl_rsp_type         crsp;
   logic [ple_pkg::VAL_W-1:0]     cell_value [ple_pkg::CAPACITY];
   logic [ple_pkg::VAL_W-1:0]     rd_value;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [39:0]                   rsp_data_ff;
   logic [39:0]                   rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req_tdata[2:0]),
      .item_value (req_tdata[34:3]),
      .position   (req_tdata[39:35]),
      .cmd        (cmd),
      .rsp        (crsp)
   );

   for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
      // the ends of the row feed back their own value
      ple_cell u_cell (
         .clock       (clock),
         .cell_idx    (ple_pkg::IDX_W'(i)),
         .cmd         (cmd),
         .left_value  (cell_value[(i == 0) ? 0 : i - 1]),
         .right_value (cell_value[(i == ple_pkg::CAPACITY - 1) ? i : i + 1]),
         .value       (cell_value[i])
      );
   end

   assign rd_value = crsp.rd ? cell_value[crsp.rd_idx] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, rd_value, crsp.count, crsp.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sim/ple_outcome_check.sv =====
// Watches the request and response streams of the list engine, predicts each response and compares.
module ple_outcome_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // func[2:0], item_value[34:3], position[39:35]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // status[1:0], entry_count[6:2], read_value[38:7], 0
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]                status;
      logic [ple_pkg::CNT_W-1:0] count;
      logic [ple_pkg::VAL_W-1:0] value;
   } outcome_type;

   logic [ple_pkg::VAL_W-1:0] shadow_entries [ple_pkg::CAPACITY];
   int unsigned               shadow_fill;
   outcome_type               pending_outcomes [$];

   task automatic open_slot(input int unsigned idx, input logic [ple_pkg::VAL_W-1:0] v);
      for (int unsigned i = shadow_fill; i > idx; i--) begin
         shadow_entries[i] = shadow_entries[i - 1];
      end
      shadow_entries[idx] = v;
      shadow_fill++;
   endtask

   task automatic close_slot(input int unsigned idx);
      for (int unsigned i = idx; i + 1 < shadow_fill; i++) begin
         shadow_entries[i] = shadow_entries[i + 1];
      end
      shadow_fill--;
   endtask

   // applies one request to the shadow list and returns the response it should produce
   task automatic apply_list_op(input logic [2:0] fn, input logic [ple_pkg::VAL_W-1:0] val,
                                input logic [4:0] pos, output outcome_type res);
      int unsigned p;
      p = pos;
      res = '0;
      res.status = ple_pkg::ST_OK;
      case (fn)
         ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK, ple_pkg::FN_INS_AT: begin
            // fullness wins over a bad position
            if (shadow_fill >= ple_pkg::CAPACITY) res.status = ple_pkg::ST_FULL;
            else if (fn == ple_pkg::FN_INS_FRONT) open_slot(0, val);
            else if (fn == ple_pkg::FN_INS_BACK) open_slot(shadow_fill, val);
            else if (p < 1 || p > shadow_fill + 1) res.status = ple_pkg::ST_BADPOS;
            else open_slot(p - 1, val);
         end
         ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_BACK, ple_pkg::FN_DEL_AT,
         ple_pkg::FN_READ: begin
            // emptiness wins over a bad position
            if (shadow_fill == 0) res.status = ple_pkg::ST_EMPTY;
            else if (fn == ple_pkg::FN_DEL_FRONT) close_slot(0);
            else if (fn == ple_pkg::FN_DEL_BACK) close_slot(shadow_fill - 1);
            else if (p < 1 || p > shadow_fill) res.status = ple_pkg::ST_BADPOS;
            else if (fn == ple_pkg::FN_DEL_AT) close_slot(p - 1);
            else res.value = shadow_entries[p - 1];
         end
         default: res.status = ple_pkg::ST_BADPOS;
      endcase
      res.count = shadow_fill[ple_pkg::CNT_W-1:0];
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         shadow_fill = 0;
         pending_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.count  = rsp_tdata[6:2];
            got.value  = rsp_tdata[38:7];
            if (pending_outcomes.size() == 0) begin
               $error("response with no request outstanding: status %0d count %0d value %h",
                      got.status, got.count, got.value);
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (got.status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $error("entry_count mismatch: expected %0d, got %0d", want.count, got.count);
                  fail_count++;
               end
               if (got.value !== want.value) begin
                  $error("read_value mismatch: expected %0d, got %0d",
                         $signed(want.value), $signed(got.value));
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_list_op(req_tdata[2:0], req_tdata[34:3], req_tdata[39:35], want);
            pending_outcomes.push_back(want);
         end
      end
      pending = pending_outcomes.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// Stimulus and verdict for the positional list engine: directed corner requests, then random ones.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FN_UNUSED    = 3'd7;
   localparam int         RANDOM_ITEMS = 1350;
   localparam int         PHASE_LEN    = 270;
   localparam int         MODE_GROW    = 0;
   localparam int         MODE_SHRINK  = 1;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // func[2:0], item_value[34:3], position[39:35]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // status[1:0], entry_count[6:2], read_value[38:7], 0
   int          fail_count;
   int          pending;
   int          send_idle_pct;
   int          stall_pct;

   positional_list_engine_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ple_outcome_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_request(input logic [2:0] fn, input logic [31:0] val,
                               input logic [4:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, val, fn};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic random_request(input int mode);
      int          r;
      int          ins_share;
      logic [2:0]  fn;
      logic [31:0] val;
      logic [4:0]  pos;
      ins_share = (mode == MODE_GROW) ? 55 : (mode == MODE_SHRINK) ? 20 : 40;
      r = $urandom_range(99);
      if (r < 2) begin
         fn = FN_UNUSED;
      end else if (r < 17) begin
         fn = ple_pkg::FN_READ;
      end else if (r < 17 + ins_share) begin
         case ($urandom_range(2))
            0:       fn = ple_pkg::FN_INS_FRONT;
            1:       fn = ple_pkg::FN_INS_BACK;
            default: fn = ple_pkg::FN_INS_AT;
         endcase
      end else begin
         case ($urandom_range(2))
            0:       fn = ple_pkg::FN_DEL_FRONT;
            1:       fn = ple_pkg::FN_DEL_BACK;
            default: fn = ple_pkg::FN_DEL_AT;
         endcase
      end
      case ($urandom_range(15))
         0:       val = 32'h8000_0000;
         1:       val = 32'h7FFF_FFFF;
         2:       val = 32'h0000_0000;
         3:       val = 32'hFFFF_FFFF;
         default: val = $urandom;
      endcase
      r = $urandom_range(99);
      if (r < 8) pos = 5'd0;
      else if (r < 93) pos = 5'($urandom_range(17, 1));
      else pos = 5'($urandom_range(31, 18));
      send_request(fn, val, pos);
   endtask

   initial begin
      int mode;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      mode          = MODE_GROW;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty list: every removal and read is flagged, bad insert positions too
      send_request(ple_pkg::FN_READ, 32'h0, 5'd1);
      send_request(ple_pkg::FN_DEL_FRONT, 32'h0, 5'd0);
      send_request(ple_pkg::FN_DEL_BACK, 32'h0, 5'd0);
      send_request(ple_pkg::FN_DEL_AT, 32'h0, 5'd1);
      send_request(ple_pkg::FN_INS_AT, 32'h1111_1111, 5'd0);
      send_request(ple_pkg::FN_INS_AT, 32'h2222_2222, 5'd2);
      send_request(ple_pkg::FN_INS_AT, 32'h8000_0000, 5'd1);
      send_request(ple_pkg::FN_INS_FRONT, 32'h7FFF_FFFF, 5'd0);
      send_request(ple_pkg::FN_INS_BACK, 32'h0000_0000, 5'd0);
      send_request(ple_pkg::FN_INS_AT, 32'hFFFF_FFFF, 5'd4);   // count + 1 appends
      send_request(ple_pkg::FN_INS_AT, 32'h1234_5678, 5'd2);
      send_request(ple_pkg::FN_READ, 32'h0, 5'd0);
      send_request(ple_pkg::FN_READ, 32'h0, 5'd5);
      send_request(ple_pkg::FN_READ, 32'h0, 5'd6);
      send_request(ple_pkg::FN_READ, 32'h0, 5'd1);
      send_request(ple_pkg::FN_READ, 32'h0, 5'd2);
      send_request(ple_pkg::FN_DEL_AT, 32'h0, 5'd0);
      send_request(ple_pkg::FN_DEL_AT, 32'h0, 5'd6);
      send_request(ple_pkg::FN_DEL_AT, 32'h0, 5'd3);
      send_request(FN_UNUSED, 32'hA5A5_5A5A, 5'd31);
      send_request(ple_pkg::FN_DEL_FRONT, 32'h0, 5'd0);
      send_request(ple_pkg::FN_DEL_BACK, 32'h0, 5'd0);
      send_request(ple_pkg::FN_READ, 32'h0, 5'd31);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % PHASE_LEN == 0) begin
            case (k / PHASE_LEN)
               1:       begin send_idle_pct = 51; stall_pct = 0;  end
               2:       begin send_idle_pct = 0;  stall_pct = 51; end
               3:       begin send_idle_pct = 35; stall_pct = 35; end
               default: begin send_idle_pct = 0;  stall_pct = 0;  end
            endcase
         end
         // drift between filling up, draining and a mix so full and empty both recur
         if (k % 40 == 0) mode = $urandom_range(2);
         random_request(mode);
      end

      req_tvalid    <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine_top.sv
sim/ple_outcome_check.sv
sim/tb_top.sv
